// ----- src/assert_macros.svh -----
// Assertion macros for the time-slice scheduler.
// Used by the top level only; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("scheduler property violated");
`define ASSERT_NEVER(label, clk_s, rst_s, expr) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) \
        else $error("scheduler forbidden condition seen");
`else
`define ASSERT_PROP(label, clk_s, rst_s, prop)
`define ASSERT_NEVER(label, clk_s, rst_s, expr)
`endif
`endif

// ----- src/cbts_pkg.sv -----
// Shared types and constants for the time-slice scheduler.
// No dependencies; imported by cbts_ctrl, cbts_dp and the top level.
package cbts_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SCHED = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [1:0] TS_RUNNABLE = 2'd0;
    localparam logic [1:0] TS_SLEEPING = 2'd1;

    localparam logic [7:0]  FULL_SLICE  = 8'hff;
    localparam logic [15:0] TPS_DEFAULT = 16'd100;

    typedef struct packed {
        logic        used;
        logic [1:0]  status;
        logic [7:0]  slice;
        logic [7:0]  nice;
        logic [31:0] alarm;
    } slot_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_PASS1,
        ST_DECIDE1,
        ST_PASS2,
        ST_DECIDE2,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic pass_start;
        logic refill;
        logic pass_run;
        logic write_slot;
        logic tick_rd;
        logic tick_wr;
        logic set_run;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pass_done;
        logic any_runnable;
        logic found;
    } sts_t;

endpackage

// ----- src/cbts_ctrl.sv -----
// Sequencing state machine for the time-slice scheduler.
// Depends on cbts_pkg; drives cbts_dp through cmd_t and reads sts_t.
module cbts_ctrl import cbts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] mode,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output cmd_t       cmd,
    input  sts_t       sts
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode_t'(mode))
                        MODE_TICK:  state_next = ST_TICK_RD;
                        MODE_SCHED: state_next = ST_PASS1;
                        MODE_WRITE: state_next = ST_WRITE;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_WRITE:   state_next = ST_FINISH;
            ST_TICK_RD: state_next = ST_TICK_WR;
            ST_TICK_WR: state_next = ST_FINISH;
            ST_PASS1:
            begin
                if (sts.pass_done)
                    state_next = ST_DECIDE1;
            end
            ST_DECIDE1:
            begin
                if (sts.any_runnable && !sts.found)
                    state_next = ST_PASS2;
                else
                    state_next = ST_FINISH;
            end
            ST_PASS2:
            begin
                if (sts.pass_done)
                    state_next = ST_DECIDE2;
            end
            ST_DECIDE2: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands and handshake
    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept     = accept;
                cmd.pass_start = accept && (mode_t'(mode) == MODE_SCHED);
            end
            ST_WRITE:   cmd.write_slot = 1'b1;
            ST_TICK_RD: cmd.tick_rd = 1'b1;
            ST_TICK_WR: cmd.tick_wr = 1'b1;
            ST_PASS1:   cmd.pass_run = 1'b1;
            ST_DECIDE1:
            begin
                // nothing left with time on it: refill and rescan
                if (sts.any_runnable && !sts.found)
                begin
                    cmd.pass_start = 1'b1;
                    cmd.refill     = 1'b1;
                end
                else
                    cmd.set_run = 1'b1;
            end
            ST_PASS2:   cmd.pass_run = 1'b1;
            ST_DECIDE2: cmd.set_run = 1'b1;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:    cmd = '0;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- src/cbts_dp.sv -----
// Datapath for the time-slice scheduler: slot memory, scan pipeline,
// counters and result register. Depends on cbts_pkg; driven by cbts_ctrl.
module cbts_dp import cbts_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic [3:0]  slot,
    input  logic        used,
    input  logic [1:0]  task_status,
    input  logic [7:0]  slice_left,
    input  logic [7:0]  niceness,
    input  logic [31:0] wake_tick,
    output logic [3:0]  current_task,
    output logic        switched,
    output logic        refilled,
    output logic [31:0] tick_total,
    output logic [31:0] seconds_up
);

    localparam int SlotW = $clog2(SLOTS);

    slot_entry_t slot_mem [SLOTS];

    logic [15:0]      tps_reg;
    logic [3:0]       in_slot_reg;
    slot_entry_t      in_entry_reg;
    logic [SLOTS-1:0] vld_reg, vld_next;

    slot_entry_t      rd_data_reg;
    logic             rd_hit_reg;
    logic [SlotW-1:0] rd_idx_reg;
    logic             rd_pend_reg;
    logic [SlotW:0]   issue_idx_reg;

    logic             pass2_reg;
    logic             any_reg;
    logic             found_reg;
    logic [SlotW-1:0] best_idx_reg;
    logic [7:0]       best_slice_reg;

    logic [SlotW-1:0] run_reg, run_next;
    logic             switched_reg;
    logic             refill_reg;
    logic [31:0]      tick_reg;
    logic [15:0]      sub_reg, sub_next;
    logic [31:0]      up_reg;

    logic [3:0]       cur_out_reg;
    logic             sw_out_reg;
    logic             rf_out_reg;
    logic [31:0]      tick_out_reg;
    logic [31:0]      up_out_reg;

    logic             pass_issue;
    logic [SlotW-1:0] rd_addr;
    slot_entry_t      ent;
    logic             proc;
    logic             consid;
    logic             wake;
    logic [1:0]       status_now;
    logic             runnable;
    logic [7:0]       cand_slice;
    logic             cand_ok;
    logic [SlotW+3:0] slot_ext;
    logic [SlotW+3:0] run_ext;
    logic             slot_ok;

    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    slot_entry_t      wr_data;

    // ---------------- read side ----------------
    assign pass_issue = cmd.pass_run && (issue_idx_reg < (SlotW+1)'(SLOTS));
    assign rd_addr    = cmd.tick_rd ? run_reg : issue_idx_reg[SlotW-1:0];

    // a never-written entry reads as the reset value
    assign ent = rd_hit_reg ? rd_data_reg : '0;

    assign proc       = cmd.pass_run && rd_pend_reg;
    assign consid     = (rd_idx_reg == '0) || ent.used;
    assign wake       = !pass2_reg && consid && (ent.status == TS_SLEEPING) &&
                        (ent.alarm != '0) && (tick_reg >= ent.alarm);
    assign status_now = wake ? TS_RUNNABLE : ent.status;
    assign runnable   = consid && (status_now == TS_RUNNABLE);
    assign cand_slice = pass2_reg ? (FULL_SLICE - ent.nice) : ent.slice;
    assign cand_ok    = runnable && (pass2_reg || (ent.slice != '0)) &&
                        (!found_reg || (cand_slice > best_slice_reg));

    assign sts.pass_done    = proc && (rd_idx_reg == SlotW'(SLOTS - 1));
    assign sts.any_runnable = any_reg;
    assign sts.found        = found_reg;

    // ---------------- write side ----------------
    assign slot_ext = {SlotW'(0), in_slot_reg};
    assign slot_ok  = (32'(in_slot_reg) < SLOTS);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = ent;
        if (cmd.write_slot)
        begin
            wr_en   = slot_ok;
            wr_addr = slot_ext[SlotW-1:0];
            wr_data = in_entry_reg;
        end
        else if (cmd.tick_wr)
        begin
            wr_en         = (ent.slice != '0);
            wr_addr       = run_reg;
            wr_data.slice = ent.slice - 8'd1;
        end
        else if (proc && wake)
        begin
            wr_en          = 1'b1;
            wr_data.status = TS_RUNNABLE;
            wr_data.alarm  = '0;
        end
        else if (proc && pass2_reg && runnable)
        begin
            wr_en         = 1'b1;
            wr_data.slice = cand_slice;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
            vld_next[wr_addr] = 1'b1;
    end

    // ---------------- control state ----------------
    always_comb
    begin
        run_next = found_reg ? best_idx_reg : '0;
        sub_next = sub_reg + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg        <= TPS_DEFAULT;
            vld_reg        <= '0;
            rd_hit_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            issue_idx_reg  <= '0;
            pass2_reg      <= 1'b0;
            any_reg        <= 1'b0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_slice_reg <= '0;
            run_reg        <= '0;
            switched_reg   <= 1'b0;
            refill_reg     <= 1'b0;
            tick_reg       <= '0;
            sub_reg        <= '0;
            up_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                tps_reg <= cfg_wr_data;

            vld_reg    <= vld_next;
            rd_hit_reg <= vld_reg[rd_addr];
            rd_idx_reg <= rd_addr;

            if (cmd.accept)
            begin
                switched_reg <= 1'b0;
                refill_reg   <= 1'b0;
            end

            if (cmd.pass_start)
            begin
                issue_idx_reg  <= '0;
                rd_pend_reg    <= 1'b0;
                pass2_reg      <= cmd.refill;
                any_reg        <= 1'b0;
                found_reg      <= 1'b0;
                best_idx_reg   <= '0;
                best_slice_reg <= '0;
                if (cmd.refill)
                    refill_reg <= 1'b1;
            end
            else
            begin
                rd_pend_reg <= pass_issue;
                if (pass_issue)
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                if (proc)
                begin
                    any_reg <= any_reg || runnable;
                    if (cand_ok)
                    begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= rd_idx_reg;
                        best_slice_reg <= cand_slice;
                    end
                end
            end

            if (cmd.set_run)
            begin
                run_reg      <= run_next;
                switched_reg <= (run_next != run_reg);
            end

            if (cmd.tick_rd)
            begin
                tick_reg <= tick_reg + 32'd1;
                if (sub_next >= tps_reg)
                begin
                    sub_reg <= '0;
                    up_reg  <= up_reg + 32'd1;
                end
                else
                    sub_reg <= sub_next;
            end
        end
    end

    // ---------------- payload capture and result ----------------
    assign run_ext = {4'b0, run_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_slot_reg        <= slot;
            in_entry_reg.used  <= used;
            in_entry_reg.status <= task_status;
            in_entry_reg.slice <= slice_left;
            in_entry_reg.nice  <= niceness;
            in_entry_reg.alarm <= wake_tick;
        end
        if (cmd.load_out)
        begin
            cur_out_reg  <= run_ext[3:0];
            sw_out_reg   <= switched_reg;
            rf_out_reg   <= refill_reg;
            tick_out_reg <= tick_reg;
            up_out_reg   <= up_reg;
        end
    end

    assign current_task = cur_out_reg;
    assign switched     = sw_out_reg;
    assign refilled     = rf_out_reg;
    assign tick_total   = tick_out_reg;
    assign seconds_up   = up_out_reg;

endmodule

// ----- src/counter_based_task_scheduler.sv -----
// Time-slice counter task scheduler, one transaction at a time.
// A schedule scans the slot memory once, or twice when slices are refilled
// (one slot per cycle per memory scan).
// Throughput: next transaction taken once the previous result is registered.
// Reset (async, active low) clears counters, running slot and the slot valid bits;
// never-written slots read as empty, runnable, zero.
`include "assert_macros.svh"

module counter_based_task_scheduler import cbts_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [3:0]  slot,
    input  logic        used,
    input  logic [1:0]  task_status,
    input  logic [7:0]  slice_left,
    input  logic [7:0]  niceness,
    input  logic [31:0] wake_tick,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  current_task,
    output logic        switched,
    output logic        refilled,
    output logic [31:0] tick_total,
    output logic [31:0] seconds_up
);

    cmd_t cmd;
    sts_t sts;

    cbts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    cbts_dp #(
        .SLOTS (SLOTS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .slot         (slot),
        .used         (used),
        .task_status  (task_status),
        .slice_left   (slice_left),
        .niceness     (niceness),
        .wake_tick    (wake_tick),
        .current_task (current_task),
        .switched     (switched),
        .refilled     (refilled),
        .tick_total   (tick_total),
        .seconds_up   (seconds_up)
    );

    // busy in the cycle after every accepted transaction
    `ASSERT_PROP(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
    // a result only appears at the end of a busy period
    `ASSERT_PROP(a_result_from_busy, clk, rst_n, $rose(out_valid) |-> $past(in_stall))
    // a fresh scan cannot report its last slot straight away
    `ASSERT_PROP(a_scan_restart, clk, rst_n, cmd.pass_start |=> !sts.pass_done)
    `ASSERT_NEVER(a_cmd_clash, clk, rst_n,
        !$onehot0({cmd.write_slot, cmd.tick_rd, cmd.tick_wr,
                   cmd.pass_run, cmd.set_run, cmd.load_out}))

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for counter_based_task_scheduler: queued driver, clocked monitor
// and an in-bench scheduler predictor. Depends on cbts_pkg and the RTL only.
module tb;
    import cbts_pkg::*;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_GAP   = 2 * SLOTS + 10;
    localparam int HOLD_CYCLES = 400;
    localparam int NPHASE      = 6;

    localparam logic [1:0] TS_WAITING = 2'd2;
    localparam logic [1:0] TS_OTHER   = 2'd3;

    typedef struct {
        mode_t       mode;
        logic [3:0]  slot;
        logic        used;
        logic [1:0]  status;
        logic [7:0]  slice;
        logic [7:0]  nice;
        logic [31:0] alarm;
    } job_t;

    typedef struct {
        logic [3:0]  task_id;
        logic        sw;
        logic        refill;
        logic [31:0] ticks;
        logic [31:0] secs;
    } outcome_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  mode        = '0;
    logic [3:0]  slot        = '0;
    logic        used        = 1'b0;
    logic [1:0]  task_status = '0;
    logic [7:0]  slice_left  = '0;
    logic [7:0]  niceness    = '0;
    logic [31:0] wake_tick   = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [3:0]  current_task;
    logic        switched;
    logic        refilled;
    logic [31:0] tick_total;
    logic [31:0] seconds_up;

    counter_based_task_scheduler #(.SLOTS(SLOTS)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .slot         (slot),
        .used         (used),
        .task_status  (task_status),
        .slice_left   (slice_left),
        .niceness     (niceness),
        .wake_tick    (wake_tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .current_task (current_task),
        .switched     (switched),
        .refilled     (refilled),
        .tick_total   (tick_total),
        .seconds_up   (seconds_up)
    );

    // predictor state
    logic        tbl_used   [SLOTS] = '{default: 1'b0};
    logic [1:0]  tbl_status [SLOTS] = '{default: 2'd0};
    logic [7:0]  tbl_slice  [SLOTS] = '{default: 8'd0};
    logic [7:0]  tbl_nice   [SLOTS] = '{default: 8'd0};
    logic [31:0] tbl_alarm  [SLOTS] = '{default: 32'd0};
    logic [3:0]  run_slot   = '0;
    logic [31:0] tick_cnt   = '0;
    logic [15:0] sub_cnt    = '0;
    logic [31:0] up_cnt     = '0;
    logic [15:0] tps        = TPS_DEFAULT;

    job_t     job_q[$];
    outcome_t outcome_q[$];
    logic [31:0] tick_est = '0;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_req       = 0;
    int  hold_ack       = 0;
    int  hold_left      = 0;
    int  mismatches     = 0;
    int  cycles         = 0;
    bit  in_taken       = 1'b0;

    always #2 clk = ~clk;

    task automatic advance_scheduler(input job_t j, output outcome_t o);
        logic [3:0] prev;
        logic       rf;
        logic       any_run;
        logic       found;
        int         best;
        int         i;
        rf   = 1'b0;
        o.sw = 1'b0;
        case (j.mode)
            MODE_TICK:
            begin
                tick_cnt = tick_cnt + 32'd1;
                sub_cnt  = sub_cnt + 16'd1;
                if (sub_cnt >= tps)
                begin
                    sub_cnt = '0;
                    up_cnt  = up_cnt + 32'd1;
                end
                if (tbl_slice[run_slot] != 0)
                    tbl_slice[run_slot] = tbl_slice[run_slot] - 8'd1;
            end
            MODE_SCHED:
            begin
                prev    = run_slot;
                any_run = 1'b0;
                found   = 1'b0;
                best    = 0;
                for (i = 0; i < SLOTS; i++)
                begin
                    if (i != 0 && !tbl_used[i])
                        continue;
                    if (tbl_status[i] == TS_SLEEPING && tbl_alarm[i] != 0 &&
                        tick_cnt >= tbl_alarm[i])
                    begin
                        tbl_alarm[i]  = '0;
                        tbl_status[i] = TS_RUNNABLE;
                    end
                    if (tbl_status[i] != TS_RUNNABLE)
                        continue;
                    any_run = 1'b1;
                    if (tbl_slice[i] != 0 && (!found || tbl_slice[i] > tbl_slice[best]))
                    begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (any_run && !found)
                begin
                    // nobody has time left: refill every runnable slot and choose again
                    rf = 1'b1;
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if ((i != 0 && !tbl_used[i]) || tbl_status[i] != TS_RUNNABLE)
                            continue;
                        tbl_slice[i] = FULL_SLICE - tbl_nice[i];
                        if (!found || tbl_slice[i] > tbl_slice[best])
                        begin
                            best  = i;
                            found = 1'b1;
                        end
                    end
                end
                run_slot = any_run ? best[3:0] : 4'd0;
                o.sw     = (run_slot != prev);
            end
            MODE_WRITE:
            begin
                tbl_used[j.slot]   = j.used;
                tbl_status[j.slot] = j.status;
                tbl_slice[j.slot]  = j.slice;
                tbl_nice[j.slot]   = j.nice;
                tbl_alarm[j.slot]  = j.alarm;
            end
            default: ;
        endcase
        o.task_id = run_slot;
        o.refill  = rf;
        o.ticks   = tick_cnt;
        o.secs    = up_cnt;
    endtask

    function automatic job_t make_job(mode_t m, logic [3:0] s, logic u, logic [1:0] st,
                                      logic [7:0] sl, logic [7:0] nc, logic [31:0] al);
        job_t j;
        j.mode   = m;
        j.slot   = s;
        j.used   = u;
        j.status = st;
        j.slice  = sl;
        j.nice   = nc;
        j.alarm  = al;
        return j;
    endfunction

    task automatic queue_job(input job_t j);
        job_q.push_back(j);
        if (j.mode == MODE_TICK)
            tick_est = tick_est + 32'd1;
    endtask

    function automatic job_t random_job();
        job_t j;
        int   r;
        j = make_job(mode_t'($urandom_range(3)), 4'($urandom_range(15)),
                     1'($urandom_range(1)), 2'($urandom_range(3)),
                     8'($urandom), 8'($urandom), $urandom);
        r = $urandom_range(99);
        if (r < 38)
            j.mode = MODE_TICK;
        else if (r < 62)
            j.mode = MODE_SCHED;
        else if (r < 95)
            j.mode = MODE_WRITE;
        else
            j.mode = MODE_NONE;
        if (j.mode == MODE_WRITE)
        begin
            j.used = ($urandom_range(9) != 0);
            r = $urandom_range(99);
            j.status = (r < 50) ? TS_RUNNABLE : (r < 80) ? TS_SLEEPING :
                       (r < 90) ? TS_WAITING : TS_OTHER;
            case ($urandom_range(3))
                0: j.slice = 8'd0;
                1: j.slice = 8'hff;
                default: ;
            endcase
            r = $urandom_range(99);
            if (r < 2)
                j.nice = 8'hff;
            else if (r == 2)
                j.nice = 8'd0;
            r = $urandom_range(99);
            // mostly alarms close to the current tick, some already past
            if (r < 15)
                j.alarm = '0;
            else if (r >= 30)
                j.alarm = tick_est - 32'd3 + $urandom_range(25);
        end
        return j;
    endfunction

    task automatic wait_drained();
        while (!(job_q.size() == 0 && !in_valid && outcome_q.size() == 0))
            @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        job_t j;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (job_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                j = job_q.pop_front();
                mode        <= j.mode;
                slot        <= j.slot;
                used        <= j.used;
                task_status <= j.status;
                slice_left  <= j.slice;
                niceness    <= j.nice;
                wake_tick   <= j.alarm;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls plus the occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_ack != hold_req)
        begin
            hold_ack = hold_ack + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: check results, then predict newly accepted transactions
    always @(posedge clk)
    begin
        job_t     j;
        outcome_t want;
        outcome_t seen;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.task_id = current_task;
                seen.sw      = switched;
                seen.refill  = refilled;
                seen.ticks   = tick_total;
                seen.secs    = seconds_up;
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: task=%0d sw=%0b rf=%0b ticks=%0d secs=%0d",
                                 seen.task_id, seen.sw, seen.refill, seen.ticks, seen.secs);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (want.task_id !== seen.task_id || want.sw !== seen.sw ||
                        want.refill !== seen.refill || want.ticks !== seen.ticks ||
                        want.secs !== seen.secs)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp task=%0d sw=%0b rf=%0b ticks=%0d secs=%0d",
                                      " got task=%0d sw=%0b rf=%0b ticks=%0d secs=%0d"},
                                     want.task_id, want.sw, want.refill, want.ticks, want.secs,
                                     seen.task_id, seen.sw, seen.refill, seen.ticks, seen.secs);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                j.mode   = mode_t'(mode);
                j.slot   = slot;
                j.used   = used;
                j.status = task_status;
                j.slice  = slice_left;
                j.nice   = niceness;
                j.alarm  = wake_tick;
                advance_scheduler(j, want);
                outcome_q.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int phase_items [NPHASE] = '{300, 300, 300, 300, 350, 350};
        int phase_idle  [NPHASE] = '{0, 69, 0, 26, 0, 26};
        int phase_stall [NPHASE] = '{0, 0, 69, 26, 0, 26};
        int phase_tps   [NPHASE] = '{100, 1, 65535, 0, 0, 7};
        int p;
        int n;

        // directed: slot 0 always considered, refill from reset
        queue_job(make_job(MODE_SCHED, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        queue_job(make_job(MODE_TICK, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        queue_job(make_job(MODE_TICK, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        queue_job(make_job(MODE_NONE, 4'd15, 1'b1, TS_OTHER, 8'hff, 8'hff, 32'hffff_ffff));
        queue_job(make_job(MODE_WRITE, 4'd15, 1'b1, TS_RUNNABLE, 8'hff, 8'd0, 32'hffff_ffff));
        queue_job(make_job(MODE_WRITE, 4'd5, 1'b1, TS_SLEEPING, 8'd200, 8'hff, 32'd3));
        queue_job(make_job(MODE_SCHED, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        queue_job(make_job(MODE_TICK, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        // alarm reached: slot 5 wakes
        queue_job(make_job(MODE_SCHED, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        // tick still decrements the running slot once it is marked unused
        queue_job(make_job(MODE_WRITE, 4'd15, 1'b0, TS_RUNNABLE, 8'd10, 8'd0, 32'd0));
        queue_job(make_job(MODE_TICK, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        queue_job(make_job(MODE_WRITE, 4'd7, 1'b1, TS_WAITING, 8'hff, 8'd0, 32'd0));
        queue_job(make_job(MODE_WRITE, 4'd8, 1'b1, TS_OTHER, 8'hff, 8'd0, 32'd0));
        queue_job(make_job(MODE_WRITE, 4'd9, 1'b1, TS_SLEEPING, 8'hff, 8'd0, 32'd0));
        queue_job(make_job(MODE_SCHED, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        // nothing runnable at all
        queue_job(make_job(MODE_WRITE, 4'd0, 1'b0, TS_OTHER, 8'd0, 8'd0, 32'd0));
        queue_job(make_job(MODE_WRITE, 4'd5, 1'b1, TS_WAITING, 8'd0, 8'd0, 32'd0));
        queue_job(make_job(MODE_SCHED, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        // refill with every nice at maximum gives zero slices
        queue_job(make_job(MODE_WRITE, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'hff, 32'd0));
        queue_job(make_job(MODE_WRITE, 4'd3, 1'b1, TS_RUNNABLE, 8'd0, 8'hff, 32'd0));
        queue_job(make_job(MODE_SCHED, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));
        // tie: earliest slot wins
        queue_job(make_job(MODE_WRITE, 4'd2, 1'b1, TS_RUNNABLE, 8'd100, 8'd0, 32'd0));
        queue_job(make_job(MODE_WRITE, 4'd4, 1'b1, TS_RUNNABLE, 8'd100, 8'd0, 32'd0));
        queue_job(make_job(MODE_SCHED, 4'd0, 1'b0, TS_RUNNABLE, 8'd0, 8'd0, 32'd0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (p = 0; p < NPHASE; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                repeat (DRAIN_GAP) @(posedge clk);
                @(negedge clk);
                cfg_wr_en   = 1'b1;
                cfg_wr_data = (p == 4) ? 16'($urandom_range(2, 500)) : 16'(phase_tps[p]);
                tps         = cfg_wr_data;
                @(negedge clk);
                cfg_wr_en   = 1'b0;
            end
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (n = 0; n < phase_items[p]; n++)
                queue_job(random_job());
            if (p == 2)
                hold_req = hold_req + 1;
        end

        wait_drained();
        repeat (DRAIN_GAP) @(posedge clk);
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/cbts_pkg.sv
src/cbts_ctrl.sv
src/cbts_dp.sv
src/counter_based_task_scheduler.sv
bench/tb.sv
